// ===== design/tapc_pkg.sv =====
// Shared types, widths and codes for the two-axis encoder PID position controller.
// Depends on nothing; imported by tapc_pid_axis and the top level.

package tapc_pkg;

   // Datapath widths
   localparam int POS_BITS   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int SUM_BITS   = 48;
   localparam int GAIN_BITS  = 32;
   localparam int MS_BITS    = 32;
   localparam int DEB_BITS   = 16;
   localparam int DUTY_BITS  = 8;
   localparam int OP_BITS    = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // Error, error difference and the split points of the multiplier operands
   localparam int ERR_BITS  = POS_BITS + 1;
   localparam int DERR_BITS = POS_BITS + 2;
   localparam int ERR_LO    = ERR_BITS / 2;
   localparam int DERR_LO   = DERR_BITS / 2;
   localparam int SUM_LO    = SUM_BITS / 2;

   // Full-precision controller sum and its floored integer part
   localparam int U_BITS   = GAIN_BITS + ((SUM_BITS > DERR_BITS) ? SUM_BITS : DERR_BITS) + 2;
   localparam int DRV_BITS = U_BITS - FRAC_BITS;

   // Pipeline stages, request acceptance to result register
   localparam int NUM_STAGES = 5;
   localparam int STG_S1  = 0;
   localparam int STG_S2  = 1;
   localparam int STG_S3  = 2;
   localparam int STG_S4  = 3;
   localparam int STG_OUT = 4;

   // Request operations
   localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ENC    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_LIMIT  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_TARGET = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_X_GAIN_P  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_X_GAIN_D  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_X_GAIN_I  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_Y_GAIN_P  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_Y_GAIN_D  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_Y_GAIN_I  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEBOUNCE  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_DUTY_MAX  = 3'd7;

   // Register reset values
   localparam logic signed [GAIN_BITS-1:0] RST_X_GAIN_P = 32'sd98304;
   localparam logic signed [GAIN_BITS-1:0] RST_X_GAIN_D = 32'sd983040;
   localparam logic signed [GAIN_BITS-1:0] RST_X_GAIN_I = 32'sd98;
   localparam logic signed [GAIN_BITS-1:0] RST_Y_GAIN_P = 32'sd78643;
   localparam logic signed [GAIN_BITS-1:0] RST_Y_GAIN_D = 32'sd0;
   localparam logic signed [GAIN_BITS-1:0] RST_Y_GAIN_I = 32'sd0;
   localparam logic [DEB_BITS-1:0]         RST_DEBOUNCE = 16'd300;
   localparam logic [DUTY_BITS-1:0]        RST_DUTY_MAX = 8'd255;

   // Gains of one axis
   typedef struct packed {
      logic signed [GAIN_BITS-1:0] gain_p;
      logic signed [GAIN_BITS-1:0] gain_d;
      logic signed [GAIN_BITS-1:0] gain_i;
   } gain_set_type;

   // Accepted request as seen by one axis
   typedef struct packed {
      logic                        hit;
      logic                        tick;
      logic [OP_BITS-1:0]          op;
      logic                        enc_b_level;
      logic                        limit_level;
      logic [MS_BITS-1:0]          now_ms;
      logic signed [POS_BITS-1:0]  target_value;
   } axis_event_type;

   // Pipeline control from the top level to the axis datapaths
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic                  word_we;
   } pipe_ctrl_type;

endpackage

// ===== design/tapc_pid_axis.sv =====
// One axis: position, target, debounce and PID state, and the PID datapath pipeline.
// Depends on tapc_pkg; stage loads come from the top level's pipeline control.

module tapc_pid_axis (
   input  logic                                clock,
   input  logic                                reset,
   input  tapc_pkg::pipe_ctrl_type             ctrl,
   input  tapc_pkg::axis_event_type            evt,
   input  tapc_pkg::gain_set_type              gains,
   input  logic [tapc_pkg::DEB_BITS-1:0]       debounce_ms,
   input  logic [tapc_pkg::DUTY_BITS-1:0]      duty_max,
   output logic                                forward,
   output logic [tapc_pkg::DUTY_BITS-1:0]      duty,
   output logic signed [tapc_pkg::POS_BITS-1:0] count
);
   import tapc_pkg::*;

   localparam int PE_LO_W = GAIN_BITS + ERR_LO + 1;
   localparam int PE_HI_W = GAIN_BITS + ERR_BITS - ERR_LO;
   localparam int PD_LO_W = GAIN_BITS + DERR_LO + 1;
   localparam int PD_HI_W = GAIN_BITS + DERR_BITS - DERR_LO;
   localparam int PS_LO_W = GAIN_BITS + SUM_LO + 1;
   localparam int PS_HI_W = GAIN_BITS + SUM_BITS - SUM_LO;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // Architectural state
   logic signed [POS_BITS-1:0]  pos_ff, pos_in;
   logic signed [POS_BITS-1:0]  target_ff, target_in;
   logic signed [ERR_BITS-1:0]  last_err_ff, last_err_in;
   logic signed [SUM_BITS-1:0]  err_sum_ff, err_sum_in;
   logic [MS_BITS-1:0]          last_ms_ff, last_ms_in;
   logic [DUTY_BITS:0]          word_ff, word_in;

   // Stage one
   logic signed [ERR_BITS-1:0]  err;
   logic signed [DERR_BITS-1:0] derr;
   logic signed [SUM_BITS:0]    sum_wide;
   logic signed [SUM_BITS-1:0]  sum_sat;
   logic [MS_BITS-1:0]          elapsed;
   logic                        limit_take;
   logic signed [ERR_BITS-1:0]  err_s1_ff;
   logic signed [DERR_BITS-1:0] derr_s1_ff;
   logic signed [SUM_BITS-1:0]  sum_s1_ff;
   logic signed [POS_BITS-1:0]  count_s1_ff;

   // Stage two: partial products
   logic signed [ERR_LO:0]             err_lo;
   logic signed [DERR_LO:0]            derr_lo;
   logic signed [SUM_LO:0]             sum_lo;
   logic signed [ERR_BITS-ERR_LO-1:0]  err_hi;
   logic signed [DERR_BITS-DERR_LO-1:0] derr_hi;
   logic signed [SUM_BITS-SUM_LO-1:0]  sum_hi;
   logic signed [PE_LO_W-1:0] pe_lo_ff, pe_lo_in;
   logic signed [PE_HI_W-1:0] pe_hi_ff, pe_hi_in;
   logic signed [PD_LO_W-1:0] pd_lo_ff, pd_lo_in;
   logic signed [PD_HI_W-1:0] pd_hi_ff, pd_hi_in;
   logic signed [PS_LO_W-1:0] ps_lo_ff, ps_lo_in;
   logic signed [PS_HI_W-1:0] ps_hi_ff, ps_hi_in;
   logic signed [POS_BITS-1:0] count_s2_ff;

   // Stage three: terms, stage four: full sum
   logic signed [U_BITS-1:0]   term_p_ff, term_p_in;
   logic signed [U_BITS-1:0]   term_d_ff, term_d_in;
   logic signed [U_BITS-1:0]   term_i_ff, term_i_in;
   logic signed [POS_BITS-1:0] count_s3_ff;
   logic signed [U_BITS-1:0]   u_s4_ff, u_s4_in;
   logic signed [POS_BITS-1:0] count_s4_ff;
   logic signed [POS_BITS-1:0] count_out_ff;

   // Result stage
   logic [DRV_BITS-1:0]  drive;
   logic [DRV_BITS-1:0]  drive_mag;
   logic                 drive_neg;
   logic [DUTY_BITS-1:0] duty_sat;

   // Error, derivative difference and saturated error sum
   always_comb begin
      err      = {pos_ff[POS_BITS-1], pos_ff} - {target_ff[POS_BITS-1], target_ff};
      derr     = {err[ERR_BITS-1], err} - {last_err_ff[ERR_BITS-1], last_err_ff};
      sum_wide = {err_sum_ff[SUM_BITS-1], err_sum_ff}
               + {{(SUM_BITS+1-ERR_BITS){err[ERR_BITS-1]}}, err};
      case (sum_wide[SUM_BITS:SUM_BITS-1])
         2'b01:   sum_sat = SUM_MAX;
         2'b10:   sum_sat = SUM_MIN;
         default: sum_sat = sum_wide[SUM_BITS-1:0];
      endcase
      elapsed    = evt.now_ms - last_ms_ff;
      limit_take = (elapsed > {{(MS_BITS-DEB_BITS){1'b0}}, debounce_ms}) && evt.limit_level;
   end

   // Apply the accepted request to the axis state
   always_comb begin
      pos_in      = pos_ff;
      target_in   = target_ff;
      last_ms_in  = last_ms_ff;
      last_err_in = last_err_ff;
      err_sum_in  = err_sum_ff;
      if (evt.tick) begin
         last_err_in = err;
         err_sum_in  = sum_sat;
      end
      if (evt.hit) begin
         case (evt.op)
            OP_ENC: begin
               // B high counts up, low counts down
               pos_in = pos_ff + {{(POS_BITS-1){~evt.enc_b_level}}, 1'b1};
            end
            OP_LIMIT: begin
               if (limit_take) begin
                  pos_in = '0;
               end
               last_ms_in = evt.now_ms;
            end
            OP_TARGET: begin
               target_in = evt.target_value;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         target_ff   <= '0;
         last_err_ff <= '0;
         err_sum_ff  <= '0;
         last_ms_ff  <= '0;
         word_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         target_ff   <= target_in;
         last_err_ff <= last_err_in;
         err_sum_ff  <= err_sum_in;
         last_ms_ff  <= last_ms_in;
         word_ff     <= word_in;
      end
   end

   // Split the multiplier operands into an unsigned low half and a signed high half
   always_comb begin
      err_lo  = {1'b0, err_s1_ff[ERR_LO-1:0]};
      err_hi  = err_s1_ff[ERR_BITS-1:ERR_LO];
      derr_lo = {1'b0, derr_s1_ff[DERR_LO-1:0]};
      derr_hi = derr_s1_ff[DERR_BITS-1:DERR_LO];
      sum_lo  = {1'b0, sum_s1_ff[SUM_LO-1:0]};
      sum_hi  = sum_s1_ff[SUM_BITS-1:SUM_LO];
      pe_lo_in = gains.gain_p * err_lo;
      pe_hi_in = gains.gain_p * err_hi;
      pd_lo_in = gains.gain_d * derr_lo;
      pd_hi_in = gains.gain_d * derr_hi;
      ps_lo_in = gains.gain_i * sum_lo;
      ps_hi_in = gains.gain_i * sum_hi;
   end

   function automatic logic signed [U_BITS-1:0] term_p_in_sum(
      input logic signed [U_BITS-1:0] a,
      input logic signed [U_BITS-1:0] b,
      input logic signed [U_BITS-1:0] c
   );
      return a + b + c;
   endfunction

   // Recombine the halves of each product at full width
   always_comb begin
      term_p_in = {{(U_BITS-PE_HI_W-ERR_LO){pe_hi_ff[PE_HI_W-1]}}, pe_hi_ff, {ERR_LO{1'b0}}}
                + {{(U_BITS-PE_LO_W){pe_lo_ff[PE_LO_W-1]}}, pe_lo_ff};
      term_d_in = {{(U_BITS-PD_HI_W-DERR_LO){pd_hi_ff[PD_HI_W-1]}}, pd_hi_ff, {DERR_LO{1'b0}}}
                + {{(U_BITS-PD_LO_W){pd_lo_ff[PD_LO_W-1]}}, pd_lo_ff};
      term_i_in = {{(U_BITS-PS_HI_W-SUM_LO){ps_hi_ff[PS_HI_W-1]}}, ps_hi_ff, {SUM_LO{1'b0}}}
                + {{(U_BITS-PS_LO_W){ps_lo_ff[PS_LO_W-1]}}, ps_lo_ff};
      u_s4_in   = term_p_in_sum(term_p_ff, term_d_ff, term_i_ff);
   end

   // Floor the Q sum, take direction and magnitude, saturate to duty_max
   always_comb begin
      drive     = u_s4_ff[U_BITS-1:FRAC_BITS];
      drive_neg = u_s4_ff[U_BITS-1];
      drive_mag = drive_neg ? (~drive + 1'b1) : drive;
      if (drive_mag > {{(DRV_BITS-DUTY_BITS){1'b0}}, duty_max}) begin
         duty_sat = duty_max;
      end else begin
         duty_sat = drive_mag[DUTY_BITS-1:0];
      end
      word_in = ctrl.word_we ? {~drive_neg, duty_sat} : word_ff;
   end

   // Advance the datapath pipeline
   always_ff @(posedge clock) begin
      if (ctrl.load[STG_S1]) begin
         err_s1_ff   <= err;
         derr_s1_ff  <= derr;
         sum_s1_ff   <= sum_sat;
         count_s1_ff <= pos_in;
      end
      if (ctrl.load[STG_S2]) begin
         pe_lo_ff    <= pe_lo_in;
         pe_hi_ff    <= pe_hi_in;
         pd_lo_ff    <= pd_lo_in;
         pd_hi_ff    <= pd_hi_in;
         ps_lo_ff    <= ps_lo_in;
         ps_hi_ff    <= ps_hi_in;
         count_s2_ff <= count_s1_ff;
      end
      if (ctrl.load[STG_S3]) begin
         term_p_ff   <= term_p_in;
         term_d_ff   <= term_d_in;
         term_i_ff   <= term_i_in;
         count_s3_ff <= count_s2_ff;
      end
      if (ctrl.load[STG_S4]) begin
         u_s4_ff     <= u_s4_in;
         count_s4_ff <= count_s3_ff;
      end
      if (ctrl.load[STG_OUT]) begin
         count_out_ff <= count_s4_ff;
      end
   end

   assign forward = word_ff[DUTY_BITS];
   assign duty    = word_ff[DUTY_BITS-1:0];
   assign count   = count_out_ff;

endmodule

// ===== design/two_axis_encoder_pid_position_controller_unit.sv =====
// Two-axis encoder PID position controller: top level with register file and pipeline control.
// Pipeline: an accepted request passes stages one to four into the result stage's rsp registers.
// Throughput: one request per cycle unless rsp_ready stalls; the error sum updates at acceptance.
// Each stage advances when it is empty or the stage after it moves, so bubbles are squeezed out.
// Reset (synchronous, active high) clears positions, targets, error sums, limit times, drive
// words and the pipeline, and returns every register to its default value.

module two_axis_encoder_pid_position_controller_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [tapc_pkg::OP_BITS-1:0]             req_op,
   input  logic                                     req_axis,
   input  logic                                     req_enc_b_level,
   input  logic                                     req_limit_level,
   input  logic [tapc_pkg::MS_BITS-1:0]             req_now_ms,
   input  logic signed [tapc_pkg::POS_BITS-1:0]     req_target_value,
   input  logic                                     csr_wr_en,
   input  logic [tapc_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [tapc_pkg::CSR_DATA_BITS-1:0]       csr_wr_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_x_forward,
   output logic [tapc_pkg::DUTY_BITS-1:0]           rsp_x_duty,
   output logic                                     rsp_y_forward,
   output logic [tapc_pkg::DUTY_BITS-1:0]           rsp_y_duty,
   output logic                                     rsp_drive_enable,
   output logic signed [tapc_pkg::POS_BITS-1:0]     rsp_x_count,
   output logic signed [tapc_pkg::POS_BITS-1:0]     rsp_y_count
);
   import tapc_pkg::*;

   // Registers
   gain_set_type         x_gains_ff, x_gains_in;
   gain_set_type         y_gains_ff, y_gains_in;
   logic [DEB_BITS-1:0]  debounce_ff, debounce_in;
   logic [DUTY_BITS-1:0] duty_max_ff, duty_max_in;

   // Pipeline control
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] tick_ff, tick_in;
   logic [NUM_STAGES-1:0] drive_en_ff, drive_en_in;
   logic [NUM_STAGES-1:0] free;
   logic                  drive_on_ff, drive_on_in;
   logic                  accept;
   logic                  req_tick;
   pipe_ctrl_type         pipe_ctrl;
   axis_event_type        x_evt, y_evt;

   // Write the addressed register
   always_comb begin
      x_gains_in  = x_gains_ff;
      y_gains_in  = y_gains_ff;
      debounce_in = debounce_ff;
      duty_max_in = duty_max_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_X_GAIN_P: x_gains_in.gain_p = csr_wr_data[GAIN_BITS-1:0];
            REG_X_GAIN_D: x_gains_in.gain_d = csr_wr_data[GAIN_BITS-1:0];
            REG_X_GAIN_I: x_gains_in.gain_i = csr_wr_data[GAIN_BITS-1:0];
            REG_Y_GAIN_P: y_gains_in.gain_p = csr_wr_data[GAIN_BITS-1:0];
            REG_Y_GAIN_D: y_gains_in.gain_d = csr_wr_data[GAIN_BITS-1:0];
            REG_Y_GAIN_I: y_gains_in.gain_i = csr_wr_data[GAIN_BITS-1:0];
            REG_DEBOUNCE: debounce_in       = csr_wr_data[DEB_BITS-1:0];
            REG_DUTY_MAX: duty_max_in       = csr_wr_data[DUTY_BITS-1:0];
            default:      duty_max_in       = duty_max_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_gains_ff  <= '{gain_p: RST_X_GAIN_P, gain_d: RST_X_GAIN_D, gain_i: RST_X_GAIN_I};
         y_gains_ff  <= '{gain_p: RST_Y_GAIN_P, gain_d: RST_Y_GAIN_D, gain_i: RST_Y_GAIN_I};
         debounce_ff <= RST_DEBOUNCE;
         duty_max_ff <= RST_DUTY_MAX;
      end else begin
         x_gains_ff  <= x_gains_in;
         y_gains_ff  <= y_gains_in;
         debounce_ff <= debounce_in;
         duty_max_ff <= duty_max_in;
      end
   end

   // A stage is free when it is empty or its contents move on this cycle
   always_comb begin
      free[STG_OUT] = !valid_ff[STG_OUT] || rsp_ready;
      free[STG_S4]  = !valid_ff[STG_S4]  || free[STG_OUT];
      free[STG_S3]  = !valid_ff[STG_S3]  || free[STG_S4];
      free[STG_S2]  = !valid_ff[STG_S2]  || free[STG_S3];
      free[STG_S1]  = !valid_ff[STG_S1]  || free[STG_S2];
   end

   assign req_ready = free[STG_S1];
   assign accept    = req_valid && free[STG_S1];
   assign req_tick  = (req_op == OP_TICK);

   // Shift valid, tick and enable flags down the pipe where stages are free
   always_comb begin
      drive_on_in = drive_on_ff || (accept && req_tick);
      valid_in    = (free & {valid_ff[NUM_STAGES-2:0], req_valid})
                  | (~free & valid_ff);
      tick_in     = (free & {tick_ff[NUM_STAGES-2:0], req_tick})
                  | (~free & tick_ff);
      drive_en_in = (free & {drive_en_ff[NUM_STAGES-2:0], drive_on_in})
                  | (~free & drive_en_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         drive_on_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         drive_on_ff <= drive_on_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff     <= tick_in;
      drive_en_ff <= drive_en_in;
   end

   // Drive words change only as a tick enters the result stage
   always_comb begin
      pipe_ctrl.load    = free;
      pipe_ctrl.word_we = free[STG_OUT] && valid_ff[STG_S4] && tick_ff[STG_S4];
   end

   // Route the accepted request to each axis
   always_comb begin
      x_evt.hit          = accept && !req_axis;
      x_evt.tick         = accept && req_tick;
      x_evt.op           = req_op;
      x_evt.enc_b_level  = req_enc_b_level;
      x_evt.limit_level  = req_limit_level;
      x_evt.now_ms       = req_now_ms;
      x_evt.target_value = req_target_value;
      y_evt              = x_evt;
      y_evt.hit          = accept && req_axis;
   end

   tapc_pid_axis u_x_axis (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pipe_ctrl),
      .evt         (x_evt),
      .gains       (x_gains_ff),
      .debounce_ms (debounce_ff),
      .duty_max    (duty_max_ff),
      .forward     (rsp_x_forward),
      .duty        (rsp_x_duty),
      .count       (rsp_x_count)
   );

   tapc_pid_axis u_y_axis (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pipe_ctrl),
      .evt         (y_evt),
      .gains       (y_gains_ff),
      .debounce_ms (debounce_ff),
      .duty_max    (duty_max_ff),
      .forward     (rsp_y_forward),
      .duty        (rsp_y_duty),
      .count       (rsp_y_count)
   );

   assign rsp_valid        = valid_ff[STG_OUT];
   assign rsp_drive_enable = drive_en_ff[STG_OUT];

`ifndef SYNTH
   // A full pipe with a stalled result must refuse new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   // An accepted request occupies stage one on the next edge
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[STG_S1])
      else $error("accepted request lost at stage one");

   // Drive outputs move only when a tick enters the result stage
   a_word_move: assert property (@(posedge clock) disable iff (reset)
      (!$stable(rsp_x_duty) || !$stable(rsp_x_forward) ||
       !$stable(rsp_y_duty) || !$stable(rsp_y_forward)) |-> $past(pipe_ctrl.word_we))
      else $error("drive word changed without a tick");

   // The motor enable never falls once set
   a_enable_hold: assert property (@(posedge clock) disable iff (reset)
      drive_on_ff |=> drive_on_ff)
      else $error("drive enable cleared after first tick");
`endif

endmodule

// ===== tb/two_axis_encoder_pid_position_controller_unit_tb.sv =====
// Self-checking testbench for the two-axis encoder PID position controller unit.
// Drives requests and register writes, predicts or fixes each report and compares field by field.
// Depends on tapc_pkg and two_axis_encoder_pid_position_controller_unit.

module two_axis_encoder_pid_position_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tapc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [OP_BITS-1:0]         op;
      logic                       axis;
      logic                       enc_b_level;
      logic                       limit_level;
      logic [MS_BITS-1:0]         now_ms;
      logic signed [POS_BITS-1:0] target_value;
   } request_type;

   typedef struct packed {
      logic                       x_forward;
      logic [DUTY_BITS-1:0]       x_duty;
      logic                       y_forward;
      logic [DUTY_BITS-1:0]       y_duty;
      logic                       drive_enable;
      logic signed [POS_BITS-1:0] x_count;
      logic signed [POS_BITS-1:0] y_count;
   } report_type;

   typedef struct packed {
      request_type req;
      logic        fixed;
      report_type  want;
   } stim_row_type;

   localparam report_type BY_PREDICTOR = '0;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_BITS-1:0]         req_op = OP_TICK;
   logic                       req_axis = 1'b0;
   logic                       req_enc_b_level = 1'b0;
   logic                       req_limit_level = 1'b0;
   logic [MS_BITS-1:0]         req_now_ms = '0;
   logic signed [POS_BITS-1:0] req_target_value = '0;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index = REG_X_GAIN_P;
   logic [CSR_DATA_BITS-1:0]   csr_wr_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_x_forward;
   logic [DUTY_BITS-1:0]       rsp_x_duty;
   logic                       rsp_y_forward;
   logic [DUTY_BITS-1:0]       rsp_y_duty;
   logic                       rsp_drive_enable;
   logic signed [POS_BITS-1:0] rsp_x_count;
   logic signed [POS_BITS-1:0] rsp_y_count;

   // Controller state and register copies, index 0 is X and 1 is Y
   logic signed [POS_BITS-1:0]  axis_pos [2];
   logic signed [POS_BITS-1:0]  axis_target [2];
   logic signed [POS_BITS:0]    axis_last_err [2];
   logic signed [SUM_BITS-1:0]  axis_err_sum [2];
   logic [MS_BITS-1:0]          axis_last_limit [2];
   logic [8:0]                  drive_word [2];
   logic                        drive_on;
   logic signed [GAIN_BITS-1:0] kp [2];
   logic signed [GAIN_BITS-1:0] kd [2];
   logic signed [GAIN_BITS-1:0] ki [2];
   logic [DEB_BITS-1:0]         debounce_win;
   logic [DUTY_BITS-1:0]        duty_limit;

   report_type  pending_reports [$];
   logic        burst_mode = 1'b0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_done = 0;
   int unsigned rsp_done_seen = 0;
   int unsigned rsp_stall = 0;
   int unsigned n_requests = 0;
   int unsigned n_ticks = 0;
   int unsigned n_settings = 1;

   two_axis_encoder_pid_position_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_axis         (req_axis),
      .req_enc_b_level  (req_enc_b_level),
      .req_limit_level  (req_limit_level),
      .req_now_ms       (req_now_ms),
      .req_target_value (req_target_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_x_forward    (rsp_x_forward),
      .rsp_x_duty       (rsp_x_duty),
      .rsp_y_forward    (rsp_y_forward),
      .rsp_y_duty       (rsp_y_duty),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_x_count      (rsp_x_count),
      .rsp_y_count      (rsp_y_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // One PID update of an axis: saturating error sum, exact sum of products, floor, clamp
   function automatic logic [8:0] pid_drive_word(input logic ax);
      logic signed [127:0] err, derr, sum, acc, drive, mag, sum_hi, sum_lo;
      sum_hi = (128'sd1 <<< (SUM_BITS - 1)) - 128'sd1;
      sum_lo = -sum_hi - 128'sd1;
      err = axis_pos[ax];
      err = err - axis_target[ax];
      derr = err - axis_last_err[ax];
      sum = axis_err_sum[ax];
      sum = sum + err;
      if (sum > sum_hi) sum = sum_hi;
      else if (sum < sum_lo) sum = sum_lo;
      acc = kp[ax] * err + kd[ax] * derr + ki[ax] * sum;
      axis_err_sum[ax] = sum[SUM_BITS-1:0];
      axis_last_err[ax] = err[POS_BITS:0];
      drive = acc >>> FRAC_BITS;
      mag = (drive < 0) ? -drive : drive;
      if (mag > duty_limit) return {~drive[127], duty_limit};
      return {~drive[127], mag[DUTY_BITS-1:0]};
   endfunction

   // Apply one accepted request to the controller state and return the report it gives
   function automatic report_type advance_controller(input request_type r);
      logic [MS_BITS-1:0] elapsed;
      case (r.op)
         OP_TICK: begin
            drive_word[0] = pid_drive_word(1'b0);
            drive_word[1] = pid_drive_word(1'b1);
            drive_on = 1'b1;
         end
         OP_ENC: begin
            if (r.enc_b_level) axis_pos[r.axis] = axis_pos[r.axis] + 32'sd1;
            else axis_pos[r.axis] = axis_pos[r.axis] - 32'sd1;
         end
         OP_LIMIT: begin
            elapsed = r.now_ms - axis_last_limit[r.axis];
            if (elapsed > debounce_win && r.limit_level) axis_pos[r.axis] = '0;
            axis_last_limit[r.axis] = r.now_ms;
         end
         OP_TARGET: begin
            axis_target[r.axis] = r.target_value;
         end
      endcase
      return {drive_word[0], drive_word[1], drive_on, axis_pos[0], axis_pos[1]};
   endfunction

   function automatic request_type ev(input logic [OP_BITS-1:0] op, input logic ax,
                                      input logic b, input logic lvl,
                                      input logic [MS_BITS-1:0] now,
                                      input logic signed [POS_BITS-1:0] tgt);
      return {op, ax, b, lvl, now, tgt};
   endfunction

   function automatic report_type rep(input logic xf, input logic [7:0] xd,
                                      input logic yf, input logic [7:0] yd, input logic en,
                                      input logic signed [31:0] xc,
                                      input logic signed [31:0] yc);
      return {xf, xd, yf, yd, en, xc, yc};
   endfunction

   // Mix of full-range, small, and extreme gains
   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'($urandom_range(0, 1 << 17));
      endcase
   endfunction

   // Random request: positions walk near zero, targets mostly near position,
   // limit times mostly just inside or beyond the debounce window
   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      r.axis = 1'($urandom_range(0, 1));
      r.enc_b_level = 1'($urandom_range(0, 1));
      r.limit_level = 1'($urandom_range(0, 1));
      r.now_ms = $urandom;
      r.target_value = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 35) r.op = OP_ENC;
      else if (pick < 65) r.op = OP_TICK;
      else if (pick < 80) begin
         r.op = OP_LIMIT;
         case ($urandom_range(0, 3))
            0: r.now_ms = axis_last_limit[r.axis] + 32'(debounce_win)
                          + 32'($urandom_range(0, 1));
            1, 2: r.now_ms = axis_last_limit[r.axis] + 32'($urandom_range(0, 700));
            default: ;
         endcase
      end else begin
         r.op = OP_TARGET;
         if ($urandom_range(0, 3) != 0)
            r.target_value = axis_pos[r.axis] + 32'($urandom_range(0, 400)) - 32'sd200;
      end
      return r;
   endfunction

   // Offer one request after a random gap (none in burst mode), hold it until taken, then log its report
   task automatic send_request(input request_type r, input logic fixed,
                               input report_type want);
      int unsigned gap;
      report_type predicted;
      gap = burst_mode ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op <= r.op;
      req_axis <= r.axis;
      req_enc_b_level <= r.enc_b_level;
      req_limit_level <= r.limit_level;
      req_now_ms <= r.now_ms;
      req_target_value <= r.target_value;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_controller(r);
      pending_reports.push_back(fixed ? want : predicted);
      n_requests++;
      if (r.op == OP_TICK) n_ticks++;
   endtask

   // Drop valid and wait until every report is back and the pipeline is empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_X_GAIN_P: kp[0] = data;
         REG_X_GAIN_D: kd[0] = data;
         REG_X_GAIN_I: ki[0] = data;
         REG_Y_GAIN_P: kp[1] = data;
         REG_Y_GAIN_D: kd[1] = data;
         REG_Y_GAIN_I: ki[1] = data;
         REG_DEBOUNCE: debounce_win = data[DEB_BITS-1:0];
         REG_DUTY_MAX: duty_limit = data[DUTY_BITS-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] gpx, input logic [31:0] gdx,
                                 input logic [31:0] gix, input logic [31:0] gpy,
                                 input logic [31:0] gdy, input logic [31:0] giy,
                                 input logic [31:0] deb, input logic [31:0] dmax);
      settle();
      write_reg(REG_X_GAIN_P, gpx);
      write_reg(REG_X_GAIN_D, gdx);
      write_reg(REG_X_GAIN_I, gix);
      write_reg(REG_Y_GAIN_P, gpy);
      write_reg(REG_Y_GAIN_D, gdy);
      write_reg(REG_Y_GAIN_I, giy);
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_DUTY_MAX, dmax);
      n_settings++;
   endtask

   // Compare each accepted report with the oldest expectation
   always @(posedge clock) begin : check_reports
      report_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_x_forward, rsp_x_duty, rsp_y_forward, rsp_y_duty, rsp_drive_enable,
                rsp_x_count, rsp_y_count};
         rsp_done <= rsp_done + 1;
         if (pending_reports.size() == 0) begin
            $error("report with no request outstanding");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.x_forward !== want.x_forward) begin
               $error("x_forward: expected %0d, got %0d", want.x_forward, got.x_forward);
               fail_count++;
            end
            if (got.x_duty !== want.x_duty) begin
               $error("x_duty: expected %0d, got %0d", want.x_duty, got.x_duty);
               fail_count++;
            end
            if (got.y_forward !== want.y_forward) begin
               $error("y_forward: expected %0d, got %0d", want.y_forward, got.y_forward);
               fail_count++;
            end
            if (got.y_duty !== want.y_duty) begin
               $error("y_duty: expected %0d, got %0d", want.y_duty, got.y_duty);
               fail_count++;
            end
            if (got.drive_enable !== want.drive_enable) begin
               $error("drive_enable: expected %0d, got %0d", want.drive_enable,
                      got.drive_enable);
               fail_count++;
            end
            if (got.x_count !== want.x_count) begin
               $error("x_count: expected %0d, got %0d", want.x_count, got.x_count);
               fail_count++;
            end
            if (got.y_count !== want.y_count) begin
               $error("y_count: expected %0d, got %0d", want.y_count, got.y_count);
               fail_count++;
            end
         end
      end
   end

   // Stall the report channel for a random number of cycles after each report (none in burst mode)
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_done != rsp_done_seen) begin
            rsp_done_seen = rsp_done;
            rsp_stall = burst_mode ? 0 : $urandom_range(0, 17);
         end
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("two_axis_encoder_pid_position_controller_unit test failed");
      $finish;
   end

   initial begin
      stim_row_type stim_rows [$];

      // Initialise the predictor to the reset state
      for (int a = 0; a < 2; a++) begin
         axis_pos[a] = '0;
         axis_target[a] = '0;
         axis_last_err[a] = '0;
         axis_err_sum[a] = '0;
         axis_last_limit[a] = '0;
         drive_word[a] = '0;
      end
      drive_on = 1'b0;
      kp[0] = RST_X_GAIN_P;
      kd[0] = RST_X_GAIN_D;
      ki[0] = RST_X_GAIN_I;
      kp[1] = RST_Y_GAIN_P;
      kd[1] = RST_Y_GAIN_D;
      ki[1] = RST_Y_GAIN_I;
      debounce_win = RST_DEBOUNCE;
      duty_limit = RST_DUTY_MAX;

      // Count edges up and down before any tick: drive words read zero, enable low
      stim_rows.push_back({ev(OP_ENC, 0, 1, 0, 0, 0), 1'b1, rep(0, 0, 0, 0, 0, 1, 0)});
      stim_rows.push_back({ev(OP_ENC, 0, 0, 0, 0, 0), 1'b1, rep(0, 0, 0, 0, 0, 0, 0)});
      stim_rows.push_back({ev(OP_ENC, 0, 0, 0, 0, 0), 1'b1, rep(0, 0, 0, 0, 0, -1, 0)});
      stim_rows.push_back({ev(OP_ENC, 1, 1, 0, 0, 0), 1'b1, rep(0, 0, 0, 0, 0, -1, 1)});
      // Extreme targets, then a tick that drives both axes into the duty limit
      stim_rows.push_back({ev(OP_TARGET, 0, 0, 0, 0, 32'h7FFF_FFFF), 1'b1,
                           rep(0, 0, 0, 0, 0, -1, 1)});
      stim_rows.push_back({ev(OP_TARGET, 1, 0, 0, 0, 32'h8000_0000), 1'b1,
                           rep(0, 0, 0, 0, 0, -1, 1)});
      stim_rows.push_back({ev(OP_TICK, 0, 0, 0, 0, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, -1, 1)});
      // Limit edge exactly at the window is held off, one past it zeroes
      stim_rows.push_back({ev(OP_LIMIT, 0, 0, 1, 300, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, -1, 1)});
      stim_rows.push_back({ev(OP_LIMIT, 0, 0, 1, 601, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 1)});
      // Released switch never zeroes; elapsed time wraps through the top of the clock
      stim_rows.push_back({ev(OP_LIMIT, 1, 0, 0, 32'hFFFF_FFFF, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 1)});
      stim_rows.push_back({ev(OP_LIMIT, 1, 0, 1, 32'h0000_0100, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 1)});
      stim_rows.push_back({ev(OP_LIMIT, 1, 0, 1, 32'h0000_022D, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 0)});
      stim_rows.push_back({ev(OP_TARGET, 0, 0, 0, 0, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 0)});
      stim_rows.push_back({ev(OP_TARGET, 1, 0, 0, 0, 0), 1'b1,
                           rep(0, 255, 1, 255, 1, 0, 0)});
      // Derivative kick after the large error vanishes, then small errors
      stim_rows.push_back({ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_TICK, 1, 0, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_ENC, 1, 0, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_TARGET, 0, 0, 0, 0, -5), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_ENC, 0, 1, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_LIMIT, 0, 0, 1, 32'h8000_0000, 0), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_ENC, 0, 1, 1, 32'hFFFF_FFFF, -1), 1'b0, BY_PREDICTOR});
      // Same timestamp again: no time has passed, so no zeroing
      stim_rows.push_back({ev(OP_LIMIT, 0, 1, 1, 32'h8000_0000, -1), 1'b0, BY_PREDICTOR});
      stim_rows.push_back({ev(OP_TICK, 1, 1, 1, 32'hFFFF_FFFF, -1), 1'b0, BY_PREDICTOR});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].want);

      // Wind both error sums up with the largest errors and back down again, back to back;
      // only the integral term acts, so each drive follows the running sum, clamped to the duty limit
      apply_settings(0, 0, 100, 0, 0, 100, 0, 255);
      burst_mode = 1'b1;
      send_request(ev(OP_LIMIT, 0, 0, 1, axis_last_limit[0] + 1, 0), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_LIMIT, 1, 0, 1, axis_last_limit[1] + 1, 0), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 0, 0, 0, 0, 32'h7FFF_FFFF), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 1, 0, 0, 0, 32'h8000_0000), 1'b0, BY_PREDICTOR);
      repeat (20) send_request(ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 0, 0, 0, 0, 32'h8000_0000), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 1, 0, 0, 0, 32'h7FFF_FFFF), 1'b0, BY_PREDICTOR);
      repeat (20) send_request(ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR);
      send_request(ev(OP_TARGET, 1, 0, 0, 0, 0), 1'b0, BY_PREDICTOR);
      repeat (2) send_request(ev(OP_TICK, 0, 0, 0, 0, 0), 1'b0, BY_PREDICTOR);
      burst_mode = 1'b0;

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1: apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
            default: apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                    pick_gain(), pick_gain(), $urandom, $urandom);
         endcase
         burst_mode = (ph == 3);
         repeat (212) send_request(random_request(), 1'b0, BY_PREDICTOR);
      end
      burst_mode = 1'b0;

      settle();
      repeat (4 * NUM_STAGES) @(posedge clock);

      $display("Sent %0d requests (%0d control ticks) under %0d register settings,",
               n_requests, n_ticks, n_settings);
      $display("including a back-to-back integral wind-up run; %0d mismatches.", fail_count);
      if (fail_count == 0)
         $display("two_axis_encoder_pid_position_controller_unit test passed");
      else
         $display("two_axis_encoder_pid_position_controller_unit test failed");
      $finish;
   end

endmodule
